FILE: sv/btl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btl_pkg
// Shared types and codes of the bitmap text layout core.
// ----------------------------------------------------------------------------
package btl_pkg;

   localparam int FONTS_DEFAULT  = 4;
   localparam int GLYPHS_DEFAULT = 256;

   localparam logic [1:0] MODE_GLYPH   = 2'd0;
   localparam logic [1:0] MODE_METRICS = 2'd1;
   localparam logic [1:0] MODE_START   = 2'd2;
   localparam logic [1:0] MODE_CHAR    = 2'd3;

   localparam logic [7:0] CODE_SPACE   = 8'd32;
   localparam logic [7:0] CODE_NEWLINE = 8'd10;

   localparam int         CSR_IDX_W   = 2;
   localparam logic [1:0] CSR_SCALE_X = 2'd0;
   localparam logic [1:0] CSR_SCALE_Y = 2'd1;

   localparam logic [15:0] SCALE_RESET = 16'd256;

   typedef struct packed {
      logic [1:0]         mode;
      logic [1:0]         font;
      logic [7:0]         code;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic [7:0]         width;
      logic [7:0]         height;
      logic signed [7:0]  offset_x;
      logic signed [7:0]  offset_y;
      logic [7:0]         advance;
   } req_type;

   typedef struct packed {
      logic signed [15:0] dest_x;
      logic signed [15:0] dest_y;
      logic [11:0]        src_x;
      logic [11:0]        src_y;
      logic [7:0]         src_w;
      logic [7:0]         src_h;
      logic [1:0]         atlas_sel;
   } rsp_type;

   typedef struct packed {
      logic [11:0]       ax;
      logic [11:0]       ay;
      logic [7:0]        w;
      logic [7:0]        h;
      logic signed [7:0] ox;
      logic signed [7:0] oy;
      logic [7:0]        adv;
   } glyph_type;

   typedef struct packed {
      logic [7:0] space_adv;
      logic [7:0] line_adv;
   } metric_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_START,
      OP_SPACE,
      OP_NEWLINE,
      OP_GLYPH
   } op_type;

   // request as it enters the cursor stage
   typedef struct packed {
      op_type             op;
      logic [1:0]         font;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      glyph_type          glyph;
      logic [15:0]        dx;
      logic [15:0]        dy;
      logic [7:0]         space_adv;
   } step_type;

endpackage

FILE: sv/btl_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btl_ram
// Single-port synchronous RAM, registered read data held while not enabled.
// ----------------------------------------------------------------------------
module btl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] addr,
   input  logic [WIDTH-1:0]  wdata,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/btl_cursor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btl_cursor
// Cursor registers, blit destination and the result output register.
// ----------------------------------------------------------------------------
module btl_cursor (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic             step_valid,
   input  btl_pkg::step_type step,
   output logic             rsp_valid,
   output btl_pkg::rsp_type rsp_payload
);
   import btl_pkg::*;

   function automatic logic signed [15:0] sat16(input logic [17:0] v);
      logic signed [17:0] s;
      s = signed'(v);
      if (s > 18'sd32767) begin
         return 16'sh7fff;
      end
      if (s < -18'sd32768) begin
         return 16'sh8000;
      end
      return s[15:0];
   endfunction

   logic signed [15:0] cursor_x_ff, cursor_x_in;
   logic signed [15:0] cursor_y_ff, cursor_y_in;
   logic signed [15:0] line_x_ff, line_x_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff, rsp_in;
   logic [17:0]        cx_ext, cy_ext;

   always_comb begin
      cx_ext      = {{2{cursor_x_ff[15]}}, cursor_x_ff};
      cy_ext      = {{2{cursor_y_ff[15]}}, cursor_y_ff};
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      line_x_in   = line_x_ff;
      rsp_in.dest_x    = sat16(cx_ext + {{10{step.glyph.ox[7]}}, step.glyph.ox});
      rsp_in.dest_y    = sat16(cy_ext + {{10{step.glyph.oy[7]}}, step.glyph.oy});
      rsp_in.src_x     = step.glyph.ax;
      rsp_in.src_y     = step.glyph.ay;
      rsp_in.src_w     = step.glyph.w;
      rsp_in.src_h     = step.glyph.h;
      rsp_in.atlas_sel = step.font;
      case (step.op)
         OP_START: begin
            cursor_x_in = step.pos_x;
            cursor_y_in = step.pos_y;
            line_x_in   = step.pos_x;
         end
         OP_SPACE: begin
            cursor_x_in = sat16(cx_ext + {10'd0, step.space_adv});
         end
         OP_NEWLINE: begin
            cursor_y_in = sat16(cy_ext + {2'd0, step.dy});
            cursor_x_in = line_x_ff;
         end
         OP_GLYPH: begin
            cursor_x_in = sat16(cx_ext + {2'd0, step.dx});
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_x_ff  <= '0;
         cursor_y_ff  <= '0;
         line_x_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= step_valid && (step.op == OP_GLYPH);
         if (step_valid) begin
            cursor_x_ff <= cursor_x_in;
            cursor_y_ff <= cursor_y_in;
            line_x_ff   <= line_x_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && step_valid && (step.op == OP_GLYPH)) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_glyph_emits: assert property (@(posedge clock) disable iff (reset)
      (advance && step_valid && (step.op == OP_GLYPH)) |=> rsp_valid_ff)
      else $error("glyph step produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (advance && !(step_valid && (step.op == OP_GLYPH))) |=> !rsp_valid_ff)
      else $error("result without a glyph step");

   a_start_sets: assert property (@(posedge clock) disable iff (reset)
      (advance && step_valid && (step.op == OP_START))
         |=> (cursor_x_ff == $past(step.pos_x)) && (line_x_ff == cursor_x_ff))
      else $error("start did not load cursor and line origin");

endmodule

FILE: sv/bitmap_text_layout_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_text_layout_core
// Bitmap font text layout: glyph and metric tables, cursor, blit commands.
// ----------------------------------------------------------------------------
// Request path: table read and stage 1 load at the accepting edge, then scale into the
// stage 2 register, then cursor update and the output register.
// Throughput: one request per cycle; the glyph and metric RAMs are read or written
// once per request, and the pipeline stalls only while a blit waits on rsp_ready.
// Reset clears cursor, line origin, scales (1.0) and pipeline valids at once;
// glyph and metric tables hold no reset value and must be loaded before use.
module bitmap_text_layout_core #(
   parameter int FONTS  = btl_pkg::FONTS_DEFAULT,
   parameter int GLYPHS = btl_pkg::GLYPHS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  btl_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output btl_pkg::rsp_type                rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [btl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [15:0]                     csr_wdata
);
   import btl_pkg::*;

   localparam int DEPTH   = FONTS * GLYPHS;
   localparam int GADDR_W = $clog2(DEPTH);
   localparam int MADDR_W = (FONTS > 1) ? $clog2(FONTS) : 1;

   function automatic logic [11:0] sat12u(input logic signed [15:0] v);
      if (v < 16'sd0) begin
         return 12'd0;
      end
      if (v > 16'sd4095) begin
         return 12'hfff;
      end
      return v[11:0];
   endfunction

   logic [15:0]        scale_x_ff;
   logic [15:0]        scale_y_ff;
   logic               advance;
   logic               accept;
   logic [1:0]         font_mod;
   logic [7:0]         code_mod;
   logic [31:0]        idx_full;
   logic [GADDR_W-1:0] glyph_addr;
   logic [MADDR_W-1:0] metric_addr;
   glyph_type          glyph_wdata;
   metric_type         metric_wdata;
   logic [63:0]        glyph_rdata;
   logic [15:0]        metric_rdata;
   glyph_type          glyph_rd;
   metric_type         metric_rd;
   op_type             op_in;

   logic               s1_valid_ff;
   op_type             s1_op_ff;
   logic [1:0]         s1_font_ff;
   logic signed [15:0] s1_pos_x_ff;
   logic signed [15:0] s1_pos_y_ff;

   logic [23:0]        dx_prod;
   logic [23:0]        dy_prod;
   step_type           s2_in;
   logic               s2_valid_ff;
   step_type           s2_ff;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign accept    = req_valid && advance;
   assign csr_ready = 1'b1;

   always_comb begin
      font_mod = req_payload.font;
      for (int i = 0; i < 3; i++) begin
         if (32'(font_mod) >= FONTS) begin
            font_mod = font_mod - 2'(FONTS);
         end
      end
      code_mod = req_payload.code;
      if (32'(req_payload.code) >= GLYPHS) begin
         code_mod = req_payload.code - 8'(GLYPHS);
      end
      idx_full    = 32'(font_mod) * GLYPHS + 32'(code_mod);
      glyph_addr  = idx_full[GADDR_W-1:0];
      metric_addr = MADDR_W'(font_mod);

      glyph_wdata.ax  = sat12u(req_payload.pos_x);
      glyph_wdata.ay  = sat12u(req_payload.pos_y);
      glyph_wdata.w   = req_payload.width;
      glyph_wdata.h   = req_payload.height;
      glyph_wdata.ox  = req_payload.offset_x;
      glyph_wdata.oy  = req_payload.offset_y;
      glyph_wdata.adv = req_payload.advance;

      metric_wdata.space_adv = req_payload.advance;
      metric_wdata.line_adv  = req_payload.width;

      unique case (req_payload.mode)
         MODE_START: op_in = OP_START;
         MODE_CHAR: begin
            if (req_payload.code == CODE_SPACE) begin
               op_in = OP_SPACE;
            end else if (req_payload.code == CODE_NEWLINE) begin
               op_in = OP_NEWLINE;
            end else begin
               op_in = OP_GLYPH;
            end
         end
         default: op_in = OP_NONE;
      endcase
   end

   btl_ram #(
      .WIDTH ($bits(glyph_type)),
      .DEPTH (DEPTH)
   ) u_glyph_ram (
      .clock (clock),
      .rd_en (advance),
      .wr_en (accept && (req_payload.mode == MODE_GLYPH)),
      .addr  (glyph_addr),
      .wdata (glyph_wdata),
      .rdata (glyph_rdata)
   );

   btl_ram #(
      .WIDTH ($bits(metric_type)),
      .DEPTH (FONTS)
   ) u_metric_ram (
      .clock (clock),
      .rd_en (advance),
      .wr_en (accept && (req_payload.mode == MODE_METRICS)),
      .addr  (metric_addr),
      .wdata (metric_wdata),
      .rdata (metric_rdata)
   );

   assign glyph_rd  = glyph_type'(glyph_rdata);
   assign metric_rd = metric_type'(metric_rdata);

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_x_ff <= SCALE_RESET;
         scale_y_ff <= SCALE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SCALE_X: scale_x_ff <= csr_wdata;
            CSR_SCALE_Y: scale_y_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // stage 1: table data arrives, scale the advances
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff    <= op_in;
         s1_font_ff  <= font_mod;
         s1_pos_x_ff <= req_payload.pos_x;
         s1_pos_y_ff <= req_payload.pos_y;
      end
   end

   always_comb begin
      dx_prod         = 24'(glyph_rd.adv) * 24'(scale_x_ff);
      dy_prod         = 24'(metric_rd.line_adv) * 24'(scale_y_ff);
      s2_in.op        = s1_op_ff;
      s2_in.font      = s1_font_ff;
      s2_in.pos_x     = s1_pos_x_ff;
      s2_in.pos_y     = s1_pos_y_ff;
      s2_in.glyph     = glyph_rd;
      s2_in.dx        = dx_prod[23:8];
      s2_in.dy        = dy_prod[23:8];
      s2_in.space_adv = metric_rd.space_adv;
   end

   // stage 2 register feeding the cursor unit
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
   end

   btl_cursor u_cursor (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .step_valid  (s2_valid_ff),
      .step        (s2_ff),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted request missing from stage 1");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(s1_valid_ff) && $stable(s2_valid_ff))
      else $error("pipeline moved during stall");

   a_scale_write: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && (csr_index == CSR_SCALE_X)) |=> scale_x_ff == $past(csr_wdata))
      else $error("scale_x write lost");

endmodule

FILE: tb/bitmap_text_layout_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_text_layout_core_tb
// Self-checking bench for the bitmap text layout core. Glyph and metric tables
// are loaded through the request channel. Text is then laid out under several
// horizontal and vertical scale settings. Every blit is checked field by field
// against a behavioral layout model kept in the bench. Request pacing and blit
// backpressure are random.
// ----------------------------------------------------------------------------
module bitmap_text_layout_core_tb;
   import btl_pkg::*;

   localparam int         GLYPH_COUNT  = 256;
   localparam int         DRAIN_CYCLES = 12;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam int         PHASE_ITEMS  = 150;
   localparam logic [1:0] CSR_SPARE_2  = 2'd2;
   localparam logic [1:0] CSR_SPARE_3  = 2'd3;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   req_type     req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b0;
   rsp_type     rsp_payload;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index   = '0;
   logic [15:0] csr_wdata   = '0;

   // layout model state
   glyph_type   glyph_store [0:4*GLYPH_COUNT-1];
   bit          glyph_written [0:4*GLYPH_COUNT-1];
   int          glyph_slots [$];
   metric_type  font_metrics [0:3];
   int          cursor_x    = 0;
   int          cursor_y    = 0;
   int          line_x      = 0;
   logic [15:0] scale_x     = SCALE_RESET;
   logic [15:0] scale_y     = SCALE_RESET;
   rsp_type     blit_queue [$];

   int          requests_sent = 0;
   int          blits_checked = 0;
   int          mismatches    = 0;
   int          scale_writes  = 0;
   int          cycle_count   = 0;
   int          burst_left    = 0;
   int          stall_style   = 0;
   int          stall_left    = 0;

   bitmap_text_layout_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic int sat16(input int v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic logic [11:0] clip12(input logic signed [15:0] v);
      if (v < 0) return 12'd0;
      if (v > 4095) return 12'hFFF;
      return v[11:0];
   endfunction

   function automatic void predict_layout(input req_type r);
      int        slot;
      int        step;
      glyph_type g;
      rsp_type   blit;
      slot = int'(r.font) * GLYPH_COUNT + int'(r.code);
      case (r.mode)
         MODE_GLYPH: begin
            g.ax  = clip12(r.pos_x);
            g.ay  = clip12(r.pos_y);
            g.w   = r.width;
            g.h   = r.height;
            g.ox  = r.offset_x;
            g.oy  = r.offset_y;
            g.adv = r.advance;
            glyph_store[slot] = g;
            if (!glyph_written[slot]) begin
               glyph_written[slot] = 1'b1;
               glyph_slots.insert(glyph_slots.size(), slot);
            end
         end
         MODE_METRICS: begin
            font_metrics[r.font].space_adv = r.advance;
            font_metrics[r.font].line_adv  = r.width;
         end
         MODE_START: begin
            cursor_x = $signed(r.pos_x);
            cursor_y = $signed(r.pos_y);
            line_x   = cursor_x;
         end
         default: begin
            if (r.code == CODE_SPACE) begin
               cursor_x = sat16(cursor_x + int'(font_metrics[r.font].space_adv));
            end else if (r.code == CODE_NEWLINE) begin
               step     = (int'(font_metrics[r.font].line_adv) * int'(scale_y)) >>> 8;
               cursor_y = sat16(cursor_y + step);
               cursor_x = line_x;
            end else begin
               g              = glyph_store[slot];
               step           = (int'(g.adv) * int'(scale_x)) >>> 8;
               blit.dest_x    = 16'(sat16(cursor_x + int'($signed(g.ox))));
               blit.dest_y    = 16'(sat16(cursor_y + int'($signed(g.oy))));
               blit.src_x     = g.ax;
               blit.src_y     = g.ay;
               blit.src_w     = g.w;
               blit.src_h     = g.h;
               blit.atlas_sel = r.font;
               blit_queue.insert(blit_queue.size(), blit);
               cursor_x = sat16(cursor_x + step);
            end
         end
      endcase
   endfunction

   function automatic req_type make_req(input logic [1:0] mode, input logic [1:0] font,
                                        input logic [7:0] code, input int px, input int py,
                                        input int w, input int h, input int ox, input int oy,
                                        input int adv);
      req_type r;
      r.mode     = mode;
      r.font     = font;
      r.code     = code;
      r.pos_x    = 16'(px);
      r.pos_y    = 16'(py);
      r.width    = 8'(w);
      r.height   = 8'(h);
      r.offset_x = 8'(ox);
      r.offset_y = 8'(oy);
      r.advance  = 8'(adv);
      return r;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int      pick;
      int      slot;
      r.font     = 2'($urandom());
      r.code     = 8'($urandom());
      r.pos_x    = 16'($urandom());
      r.pos_y    = 16'($urandom());
      r.width    = 8'($urandom());
      r.height   = 8'($urandom());
      r.offset_x = 8'($urandom());
      r.offset_y = 8'($urandom());
      r.advance  = 8'($urandom());
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
         r.mode = MODE_GLYPH;
         if ($urandom_range(0, 1) == 0) begin
            r.pos_x = 16'($urandom_range(0, 4095));
            r.pos_y = 16'($urandom_range(0, 4095));
         end
      end else if (pick < 13) begin
         r.mode = MODE_METRICS;
      end else if (pick < 18) begin
         r.mode = MODE_START;
         if ($urandom_range(0, 4) != 0) begin
            r.pos_x = 16'($urandom_range(0, 4000) - 2000);
            r.pos_y = 16'($urandom_range(0, 4000) - 2000);
         end
      end else begin
         r.mode = MODE_CHAR;
         pick   = $urandom_range(0, 99);
         if (pick < 10) begin
            r.code = CODE_SPACE;
         end else if (pick < 17) begin
            r.code = CODE_NEWLINE;
         end else begin
            slot   = glyph_slots[$urandom_range(0, glyph_slots.size() - 1)];
            r.font = 2'(slot / GLYPH_COUNT);
            r.code = 8'(slot % GLYPH_COUNT);
         end
      end
      return r;
   endfunction

   // callers enter and leave on a rising edge
   task automatic send_req(input req_type r);
      int gap;
      if (burst_left == 0) begin
         gap        = $urandom_range(0, 6);
         burst_left = $urandom_range(1, 40);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      predict_layout(r);
      requests_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (blit_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_SCALE_X) begin
         scale_x = data;
      end else if (idx == CSR_SCALE_Y) begin
         scale_y = data;
      end
      scale_writes++;
      @(posedge clock);
   endtask

   task automatic set_scales(input logic [15:0] sx, input logic [15:0] sy);
      wait_idle();
      csr_write(CSR_SCALE_X, sx);
      csr_write(CSR_SCALE_Y, sy);
   endtask

   task automatic run_layout(input int count);
      for (int i = 0; i < count; i++) begin
         send_req(random_req());
         if (i == count / 2 && $urandom_range(0, 1) == 1) wait_idle();
      end
   endtask

   // tables, cursor moves, saturation at reset scales
   task automatic test_directed();
      send_req(make_req(MODE_METRICS, 2'd0, 8'd0, 0, 0, 12, 0, 0, 0, 5));
      send_req(make_req(MODE_METRICS, 2'd1, 8'd0, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_METRICS, 2'd2, 8'd0, 0, 0, 255, 0, 0, 0, 255));
      send_req(make_req(MODE_METRICS, 2'd3, 8'd0, 0, 0, 9, 0, 0, 0, 7));
      send_req(make_req(MODE_GLYPH, 2'd0, 8'd65, 100, 200, 8, 12, 1, -2, 9));
      send_req(make_req(MODE_GLYPH, 2'd3, 8'd255, 32767, -32768, 255, 255, 127, 127, 255));
      send_req(make_req(MODE_GLYPH, 2'd1, 8'd0, -1, 4096, 0, 0, -128, -128, 0));
      send_req(make_req(MODE_GLYPH, 2'd2, 8'd200, 4095, 0, 17, 3, -5, 6, 128));
      send_req(make_req(MODE_START, 2'd0, 8'd0, 10, 20, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_CHAR, 2'd0, 8'd65, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_CHAR, 2'd0, CODE_SPACE, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_CHAR, 2'd3, 8'd255, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_CHAR, 2'd0, CODE_NEWLINE, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_CHAR, 2'd1, 8'd0, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_CHAR, 2'd2, 8'd200, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_START, 2'd0, 8'd0, 32767, 32767, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_CHAR, 2'd3, 8'd255, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_CHAR, 2'd2, CODE_SPACE, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_CHAR, 2'd2, CODE_NEWLINE, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_CHAR, 2'd3, 8'd255, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_START, 2'd0, 8'd0, -32768, -32768, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_CHAR, 2'd1, 8'd0, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_CHAR, 2'd0, 8'd65, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_CHAR, 2'd3, CODE_NEWLINE, 0, 0, 0, 0, 0, 0, 0));
      send_req(make_req(MODE_CHAR, 2'd2, 8'd200, 0, 0, 0, 0, 0, 0, 0));
   endtask

   task automatic test_scale_extremes();
      set_scales(16'd0, 16'hFFFF);
      run_layout(PHASE_ITEMS);
      set_scales(16'hFFFF, 16'd0);
      run_layout(PHASE_ITEMS);
   endtask

   // writes to unused indexes must leave both scales alone
   task automatic test_spare_registers();
      set_scales(SCALE_RESET, SCALE_RESET);
      csr_write(CSR_SPARE_2, 16'($urandom()));
      csr_write(CSR_SPARE_3, 16'($urandom()));
      run_layout(100);
   endtask

   task automatic test_random_scales();
      logic [15:0] sx;
      logic [15:0] sy;
      for (int p = 0; p < 5; p++) begin
         sx = (p % 2 == 0) ? 16'($urandom_range(0, 1023)) : 16'($urandom());
         sy = (p % 2 == 0) ? 16'($urandom()) : 16'($urandom_range(0, 1023));
         set_scales(sx, sy);
         run_layout(PHASE_ITEMS);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_scale_extremes();
      test_spare_registers();
      test_random_scales();
      wait_idle();
      $display("Sent %0d requests over %0d register writes; %0d blits compared.",
               requests_sent, scale_writes, blits_checked);
      $display("Covered table loads, space/newline moves, saturation and scale extremes.");
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // blit backpressure: runs of always-ready, random, mostly-stalled and periodic stall patterns
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_style <= $urandom_range(0, 3);
         stall_left  <= $urandom_range(16, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_style)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= 1'($urandom_range(0, 1));
         2:       rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= (stall_left[1:0] != 2'd0);
      endcase
   end

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : blit_check
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (blit_queue.size() == 0) begin
            $error("blit with no request pending: dest_x %0d dest_y %0d",
                   rsp_payload.dest_x, rsp_payload.dest_y);
            mismatches++;
         end else begin
            want = blit_queue.pop_front();
            check_field("dest_x", want.dest_x, rsp_payload.dest_x);
            check_field("dest_y", want.dest_y, rsp_payload.dest_y);
            check_field("src_x", want.src_x, rsp_payload.src_x);
            check_field("src_y", want.src_y, rsp_payload.src_y);
            check_field("src_w", want.src_w, rsp_payload.src_w);
            check_field("src_h", want.src_h, rsp_payload.src_h);
            check_field("atlas_sel", want.atlas_sel, rsp_payload.atlas_sel);
            blits_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d blits outstanding", cycle_count,
                  blit_queue.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

FILE: sim.f
sv/btl_pkg.sv
sv/btl_ram.sv
sv/btl_cursor.sv
sv/bitmap_text_layout_core.sv
tb/bitmap_text_layout_core_tb.sv
